/* src/lgts_pkg.sv */
// Package for the LDA Gibbs token sampler: beat types, register indexes and limits.
// No dependencies.
package lgts_pkg;

    localparam int unsigned CNT_W   = 17;
    localparam logic [16:0] CNT_MAX = 17'h1FFFF;

    // Store dimensions; the address packing relies on powers of two.
    localparam int MAX_TOPICS = 16;
    localparam int MAX_DOCS   = 1024;
    localparam int VOCAB_SIZE = 4096;
    localparam int MAX_TOKENS = 65536;

    // Configuration register indexes.
    localparam logic [2:0] REG_ALPHA = 3'd0;
    localparam logic [2:0] REG_BETA  = 3'd1;
    localparam logic [2:0] REG_VOCAB = 3'd2;
    localparam logic [2:0] REG_TOPIC = 3'd3;
    localparam logic [2:0] REG_VALID = 3'd4;

    // Token actions.
    localparam logic ACT_INIT     = 1'b0;
    localparam logic ACT_RESAMPLE = 1'b1;

    typedef struct packed {
        logic        action;
        logic [9:0]  doc_index;
        logic [15:0] token_slot;
        logic [11:0] word_id;
        logic [15:0] random_fraction;
    } t_in_beat;

    typedef struct packed {
        logic [3:0]  topic;
        logic [15:0] token_slot_out;
    } t_out_beat;

    // Divider request and reply.
    typedef struct packed {
        logic        start;
        logic [63:0] num_hi;
        logic [63:0] num_lo;
        logic [63:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quot;
    } t_div_rsp;

endpackage

/* src/lda_gibbs_token_sampler.sv */
// LDA collapsed Gibbs token sampler top level: sequencer, count memories, configuration.
// Depends on lgts_pkg and lgts_divider.
//
// One token is handled at a time. After reset a clearing pass zeroes the count
// memories before the first token is taken. An init token passes through a count
// read, a count write and the output state. A resample token visits each of the K
// topics in use in turn: count reads and partial products, then a bit-serial
// division that forms the topic weight and ends early when the quotient saturates.
// The count memories are read once per topic and the draw compares all running sums
// together. Results wait in an output register; a stalled result holds the next
// token in its output state.
module lda_gibbs_token_sampler
    import lgts_pkg::*;
#(
    parameter int FRAC_BITS  = 16
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_beat  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_beat o_data,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int TW  = $clog2(MAX_TOPICS);
    localparam int DW  = (MAX_DOCS > 1) ? $clog2(MAX_DOCS) : 1;
    localparam int WW  = $clog2(VOCAB_SIZE);
    localparam int SW  = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;
    localparam int KW  = TW + 1;
    localparam int DTA = DW + TW;
    localparam int TWA = TW + WW;
    localparam int CLRW = TWA + 1;
    localparam int CLR_N = MAX_TOPICS * VOCAB_SIZE;
    localparam int DT_N  = MAX_DOCS * MAX_TOPICS;

    // State codes.
    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_OLD   = 4'd2;
    localparam logic [3:0] S_DECRD = 4'd3;
    localparam logic [3:0] S_DECWR = 4'd4;
    localparam logic [3:0] S_WRD   = 4'd5;
    localparam logic [3:0] S_WDIV  = 4'd6;
    localparam logic [3:0] S_WWAIT = 4'd7;
    localparam logic [3:0] S_DRAW  = 4'd8;
    localparam logic [3:0] S_INCRD = 4'd9;
    localparam logic [3:0] S_INCWR = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;
    localparam logic [3:0] S_MUL   = 4'd12;
    localparam logic [3:0] S_OLDW  = 4'd13;

    // Configuration.
    logic [31:0] r_alpha, r_beta;
    logic [12:0] r_vocab;
    logic [4:0]  r_topics;
    logic        r_frozen;

    // Memories.
    logic [CNT_W-1:0] dt_mem [DT_N];
    logic [CNT_W-1:0] tw_mem [CLR_N];
    logic [TW-1:0]    tok_mem[MAX_TOKENS];
    logic [CNT_W-1:0] r_tot  [MAX_TOPICS];
    logic [63:0]      r_cum  [MAX_TOPICS];

    logic [CNT_W-1:0] r_dt_q, r_tw_q;
    logic [TW-1:0]    r_tok_q;

    logic [3:0]       r_state;
    logic [CLRW-1:0]  r_clr;
    t_in_beat         r_in;
    logic [KW-1:0]    r_keff;
    logic [KW-1:0]    r_k;
    logic [TW-1:0]    r_old;
    logic [TW-1:0]    r_t;
    logic [63:0]      r_run;
    logic [63:0]      r_wbeta;
    logic [63:0]      r_a, r_b, r_d;
    logic [63:0]      r_p00, r_p01, r_p10, r_p11;
    logic [63:0]      r_thr;
    logic             r_ovalid;
    t_out_beat        r_out;

    t_div_req div_req;
    t_div_rsp div_rsp;

    logic [DW-1:0]  doc_a;
    logic [WW-1:0]  word_a;
    logic [SW-1:0]  slot_a;
    logic [TW-1:0]  cur_t;
    logic [DTA-1:0] dt_addr;
    logic [TWA-1:0] tw_addr;
    logic [4:0]     keff_c;
    logic [CNT_W-1:0] dt_new, tw_new, tot_new;
    logic           dec;
    logic [63:0]    mid;
    logic [63:0]    prod_lo, prod_hi;

    assign doc_a  = r_in.doc_index[DW-1:0];
    assign word_a = r_in.word_id[WW-1:0];
    assign slot_a = SW'(r_in.token_slot);
    assign dec    = (r_state == S_DECRD) || (r_state == S_DECWR);
    assign cur_t  = (r_state == S_WRD || r_state == S_WDIV || r_state == S_WWAIT ||
                     r_state == S_MUL) ? r_k[TW-1:0] : (dec ? r_old : r_t);
    assign dt_addr = {doc_a, cur_t};
    assign tw_addr = {cur_t, word_a};

    // Effective topic count.
    always_comb begin
        keff_c = r_topics;
        if (keff_c == 5'd0) begin
            keff_c = 5'd1;
        end
        if (32'(keff_c) > MAX_TOPICS) begin
            keff_c = 5'(MAX_TOPICS);
        end
    end

    // Saturating update of the counts just read.
    always_comb begin
        if (dec) begin
            dt_new  = (r_dt_q == '0) ? r_dt_q : r_dt_q - 1'b1;
            tw_new  = (r_tw_q == '0) ? r_tw_q : r_tw_q - 1'b1;
            tot_new = (r_tot[cur_t] == '0) ? r_tot[cur_t] : r_tot[cur_t] - 1'b1;
        end else begin
            dt_new  = (r_dt_q == CNT_MAX) ? r_dt_q : r_dt_q + 1'b1;
            tw_new  = (r_tw_q == CNT_MAX) ? r_tw_q : r_tw_q + 1'b1;
            tot_new = (r_tot[cur_t] == CNT_MAX) ? r_tot[cur_t] : r_tot[cur_t] + 1'b1;
        end
    end

    // 128-bit product from registered 32x32 partial products.
    assign mid     = {32'd0, r_p00[63:32]} + {32'd0, r_p01[31:0]} + {32'd0, r_p10[31:0]};
    assign prod_lo = {mid[31:0], r_p00[31:0]};
    assign prod_hi = r_p11 + {32'd0, r_p01[63:32]} + {32'd0, r_p10[63:32]} +
                     {32'd0, mid[63:32]};

    assign div_req.start  = (r_state == S_WDIV);
    assign div_req.num_hi = prod_hi;
    assign div_req.num_lo = prod_lo;
    assign div_req.den    = r_d;

    lgts_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Count memories: synchronous read, written in clear pass or on update.
    always_ff @(posedge i_clk) begin
        r_dt_q  <= dt_mem[dt_addr];
        r_tw_q  <= tw_mem[tw_addr];
        r_tok_q <= tok_mem[slot_a];
        if (r_state == S_CLEAR) begin
            tw_mem[r_clr[TWA-1:0]] <= '0;
            if (32'(r_clr) < DT_N) begin
                dt_mem[r_clr[DTA-1:0]] <= '0;
            end
        end else if (r_state == S_DECWR || r_state == S_INCWR) begin
            dt_mem[dt_addr] <= dt_new;
            if (!r_frozen) begin
                tw_mem[tw_addr] <= tw_new;
            end
            if (r_state == S_INCWR) begin
                tok_mem[slot_a] <= r_t;
            end
        end
    end

    // Configuration registers; never written in the cycle a token beat is taken.
    assign o_cfg_ready = (r_state == S_IDLE && !i_valid) || (r_state == S_CLEAR);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha  <= 32'd6554;
            r_beta   <= 32'd655;
            r_vocab  <= 13'd4096;
            r_topics <= 5'd16;
            r_frozen <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_ALPHA: r_alpha  <= i_cfg_data;
                REG_BETA:  r_beta   <= i_cfg_data;
                REG_VOCAB: r_vocab  <= i_cfg_data[12:0];
                REG_TOPIC: r_topics <= i_cfg_data[4:0];
                REG_VALID: r_frozen <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < MAX_TOPICS; i++) begin
                r_tot[i] <= '0;
            end
        end else begin
            if (r_ovalid && !i_stall && r_state != S_OUT) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (32'(r_clr) == CLR_N - 1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_in    <= i_data;
                        r_keff  <= KW'(keff_c);
                        r_wbeta <= {32'd0, r_beta} * {51'd0, r_vocab};
                        r_t     <= TW'(({16'd0, i_data.random_fraction} *
                                        {27'd0, keff_c}) >> 16);
                        r_state <= (i_data.action == ACT_INIT) ? S_INCRD : S_OLD;
                    end
                end
                S_OLD: r_state <= S_OLDW;
                S_OLDW: begin
                    r_old   <= r_tok_q;
                    r_state <= S_DECRD;
                end
                S_DECRD: r_state <= S_DECWR;
                S_DECWR: begin
                    if (!r_frozen) begin
                        r_tot[cur_t] <= tot_new;
                    end
                    r_k     <= '0;
                    r_run   <= '0;
                    r_state <= S_WRD;
                end
                S_WRD: r_state <= S_MUL;
                S_MUL: begin
                    r_a <= ({47'd0, r_dt_q} << FRAC_BITS) + {32'd0, r_alpha};
                    r_b <= ({47'd0, r_tw_q} << FRAC_BITS) + {32'd0, r_beta};
                    r_d <= ({47'd0, r_tot[cur_t]} << FRAC_BITS) + r_wbeta;
                    r_state <= S_WWAIT;
                    r_p00 <= 64'd0;
                end
                S_WWAIT: begin
                    r_p00 <= {32'd0, r_a[31:0]} * {32'd0, r_b[31:0]};
                    r_p01 <= {32'd0, r_a[31:0]} * {32'd0, r_b[63:32]};
                    r_p10 <= {32'd0, r_a[63:32]} * {32'd0, r_b[31:0]};
                    r_p11 <= {32'd0, r_a[63:32]} * {32'd0, r_b[63:32]};
                    r_state <= S_WDIV;
                end
                S_WDIV: r_state <= S_DRAW;
                S_DRAW: begin
                    if (r_k != r_keff) begin
                        // Accumulate the finished weight.
                        if (div_rsp.done) begin
                            r_run <= r_run + {32'd0, div_rsp.quot};
                            r_cum[r_k[TW-1:0]] <= r_run + {32'd0, div_rsp.quot};
                            if (r_k + 1'b1 == r_keff) begin
                                r_thr <= {48'd0, r_in.random_fraction} *
                                         (r_run + {32'd0, div_rsp.quot});
                                r_t   <= TW'(r_keff - 1'b1);
                                r_k   <= r_keff;
                            end else begin
                                r_k     <= r_k + 1'b1;
                                r_state <= S_WRD;
                            end
                        end
                    end else begin
                        r_k     <= '0;
                        r_state <= S_INCRD;
                        for (int i = MAX_TOPICS - 1; i >= 0; i--) begin
                            if (i < 32'(r_keff) && (r_cum[i] << 16) > r_thr) begin
                                r_t <= TW'(i);
                            end
                        end
                    end
                end
                S_INCRD: r_state <= S_INCWR;
                S_INCWR: begin
                    if (!r_frozen) begin
                        r_tot[cur_t] <= tot_new;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid || !i_stall) begin
                        r_ovalid <= 1'b1;
                        r_out.topic <= 4'(r_t);
                        r_out.token_slot_out <= r_in.token_slot;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_in_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall) else $error("input taken while busy");
    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_data))) else $error("result lost");
    a_topic_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (32'(o_data.topic) < 32'(r_keff) || r_keff == '0))
        else $error("topic out of range");
`endif

endmodule

/* src/lgts_divider.sv */
// Restoring divider: floor(128-bit numerator / 64-bit divisor), saturated to 32 bits.
// Depends on lgts_pkg. One quotient bit per cycle; a division stops early once the quotient saturates.
module lgts_divider
    import lgts_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [127:0] r_num;
    logic [63:0]  r_rem;
    logic [63:0]  r_den;
    logic [31:0]  r_quot;
    logic [7:0]   r_cnt;
    logic         r_busy;
    logic         r_sat;
    logic         r_done;

    logic [64:0] n_rem_sh;
    logic        n_ge;
    logic [32:0] n_quot;

    always_comb begin
        n_rem_sh = {r_rem, r_num[127]};
        n_ge     = n_rem_sh >= {1'b0, r_den};
        n_quot   = {r_quot, n_ge};
    end

    // Control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= (i_req.den != 64'd0);
                r_done <= (i_req.den == 64'd0);
            end else if (r_busy && (r_cnt == 8'd127 || r_sat || n_quot[32])) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Datapath: shift one numerator bit per cycle.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num  <= {i_req.num_hi, i_req.num_lo};
            r_den  <= i_req.den;
            r_rem  <= 64'd0;
            r_quot <= 32'd0;
            r_cnt  <= 8'd0;
            r_sat  <= (i_req.den == 64'd0);
        end else if (r_busy) begin
            r_num  <= {r_num[126:0], 1'b0};
            r_rem  <= n_ge ? 64'(n_rem_sh - {1'b0, r_den}) : n_rem_sh[63:0];
            r_quot <= n_quot[31:0];
            r_cnt  <= r_cnt + 8'd1;
            if (n_quot[32]) begin
                r_sat <= 1'b1;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_sat ? 32'hFFFF_FFFF : r_quot;

endmodule

/* tb/lda_gibbs_token_sampler_test.sv */
// Self-checking testbench for the LDA Gibbs token sampler: directed and random token beats.
// Predicts each topic draw from its own copy of the count stores; depends on lgts_pkg.
module lda_gibbs_token_sampler_test
    import lgts_pkg::*;
();

    localparam int NTOP   = 16;
    localparam int NDOC   = 1024;
    localparam int NVOCAB = 4096;
    localparam int NSLOT  = 65536;
    localparam int LIMIT  = 20000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    t_in_beat    i_data;
    logic        o_valid;
    logic        i_stall;
    t_out_beat   o_data;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    lda_gibbs_token_sampler DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // Shadow copy of the configuration and of the count stores.
    logic [31:0] sh_alpha, sh_beta;
    logic [12:0] sh_vocab;
    logic [4:0]  sh_topics;
    logic        sh_frozen;
    logic [16:0] doc_topic_cnt [NDOC*NTOP];
    logic [16:0] word_topic_cnt [NTOP*NVOCAB];
    logic [16:0] topic_total [NTOP];
    logic [3:0]  slot_topic [NSLOT];
    bit          slot_written [NSLOT];
    int unsigned written_slots [$];

    t_out_beat   expected_draws [$];
    int          n_errors = 0;
    int          n_tokens = 0;
    int          n_resamples = 0;
    int          n_results = 0;
    longint      n_cycles = 0;
    bit          quiet = 0;

    // Clock.
    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    // Cycle counter and watchdog.
    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > LIMIT) begin
            $display("%0t: timeout with %0d draws outstanding", $time, expected_draws.size());
            $display("** lda_gibbs_token_sampler: FAILED **");
            $finish;
        end
    end

    // Receiver stall, raised about 18 percent of the time unless in a quiet stretch.
    always @(negedge i_clk) begin
        i_stall <= quiet ? 1'b0 : ($urandom_range(99) < 18);
    end

    // Compare each accepted result beat with the oldest predicted draw.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            n_results++;
            if (expected_draws.size() == 0) begin
                $display("%0t: unexpected result beat, actual topic %0d slot %h",
                         $time, o_data.topic, o_data.token_slot_out);
                n_errors++;
            end else begin
                t_out_beat e;
                e = expected_draws.pop_front();
                if (o_data.topic !== e.topic) begin
                    $display("%0t: topic mismatch, expected %0d actual %0d (slot %h)",
                             $time, e.topic, o_data.topic, e.token_slot_out);
                    n_errors++;
                end
                if (o_data.token_slot_out !== e.token_slot_out) begin
                    $display("%0t: slot echo mismatch, expected %h actual %h",
                             $time, e.token_slot_out, o_data.token_slot_out);
                    n_errors++;
                end
            end
        end
    end

    // Weight of one topic: floor(a*b/d) saturated to 32 bits.
    function automatic logic [31:0] topic_weight(logic [63:0] a, logic [63:0] b,
                                                 logic [63:0] d);
        logic [127:0] prod;
        logic [127:0] quot;
        if (d == 0) return 32'hFFFF_FFFF;
        prod = {64'd0, a} * {64'd0, b};
        quot = prod / {64'd0, d};
        if (quot > 128'hFFFF_FFFF) return 32'hFFFF_FFFF;
        return quot[31:0];
    endfunction

    function automatic void cnt_down(ref logic [16:0] c);
        if (c != 0) c = c - 1;
    endfunction

    function automatic void cnt_up(ref logic [16:0] c);
        if (c != CNT_MAX) c = c + 1;
    endfunction

    // Draw a topic for one token and update the shadow counts.
    task automatic predict_draw(input t_in_beat b);
        int          k_eff, k, t, doc_base, old;
        logic [63:0] run, thr, wbeta, a, w, d;
        logic [63:0] cum [NTOP];
        t_out_beat   r;
        k_eff = (sh_topics == 0) ? 1 : (sh_topics > NTOP) ? NTOP : int'(sh_topics);
        doc_base = b.doc_index * NTOP;
        if (b.action == ACT_INIT) begin
            t = (b.random_fraction * k_eff) >> 16;
        end else begin
            old = int'(slot_topic[b.token_slot]);
            cnt_down(doc_topic_cnt[doc_base + old]);
            if (!sh_frozen) begin
                cnt_down(word_topic_cnt[old*NVOCAB + b.word_id]);
                cnt_down(topic_total[old]);
            end
            wbeta = 64'(sh_beta) * 64'(sh_vocab);
            run = 0;
            for (k = 0; k < k_eff; k++) begin
                a = (64'(doc_topic_cnt[doc_base + k]) << 16) + 64'(sh_alpha);
                w = (64'(word_topic_cnt[k*NVOCAB + b.word_id]) << 16) + 64'(sh_beta);
                d = (64'(topic_total[k]) << 16) + wbeta;
                run += 64'(topic_weight(a, w, d));
                cum[k] = run;
            end
            thr = 64'(b.random_fraction) * run;
            t = k_eff - 1;
            for (k = 0; k < k_eff; k++) begin
                if ((cum[k] << 16) > thr) begin
                    t = k;
                    break;
                end
            end
            n_resamples++;
        end
        slot_topic[b.token_slot] = 4'(t);
        if (!slot_written[b.token_slot]) begin
            slot_written[b.token_slot] = 1;
            written_slots.insert(written_slots.size(), 32'(b.token_slot));
        end
        cnt_up(doc_topic_cnt[doc_base + t]);
        if (!sh_frozen) begin
            cnt_up(word_topic_cnt[t*NVOCAB + b.word_id]);
            cnt_up(topic_total[t]);
        end
        r.topic = 4'(t);
        r.token_slot_out = b.token_slot;
        expected_draws.insert(expected_draws.size(), r);
    endtask

    // Send one token beat, with a random idle gap before it.
    task automatic send_token(input t_in_beat b);
        int gap;
        @(negedge i_clk);
        gap = (!quiet && $urandom_range(99) < 18) ? $urandom_range(1, 4) : 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= b;
        do @(posedge i_clk); while (o_stall);
        predict_draw(b);
        n_tokens++;
    endtask

    // Lower valid and wait until every predicted draw has arrived.
    task automatic drain;
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_draws.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_ALPHA: sh_alpha  = val;
            REG_BETA:  sh_beta   = val;
            REG_VOCAB: sh_vocab  = val[12:0];
            REG_TOPIC: sh_topics = val[4:0];
            REG_VALID: sh_frozen = val[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_in_beat make_token(logic act, int doc, int slot, int word, int rf);
        t_in_beat b;
        b.action = act;
        b.doc_index = 10'(doc);
        b.token_slot = 16'(slot);
        b.word_id = 12'(word);
        b.random_fraction = 16'(rf);
        return b;
    endfunction

    // Init tokens at the extremes of every field.
    task automatic test_init_extremes;
        send_token(make_token(ACT_INIT, 0, 0, 0, 0));
        send_token(make_token(ACT_INIT, 1023, 16'hFFFF, 4095, 16'hFFFF));
        send_token(make_token(ACT_INIT, 0, 1, 4095, 16'h8000));
        send_token(make_token(ACT_INIT, 1023, 2, 0, 16'h0FFF));
        drain();
    endtask

    // Resample of written slots under the reset settings.
    task automatic test_resample_basic;
        send_token(make_token(ACT_RESAMPLE, 0, 0, 0, 0));
        send_token(make_token(ACT_RESAMPLE, 1023, 16'hFFFF, 4095, 16'hFFFF));
        send_token(make_token(ACT_RESAMPLE, 0, 1, 4095, 16'h8000));
        send_token(make_token(ACT_RESAMPLE, 1023, 2, 0, 16'h4000));
        drain();
    endtask

    // Topic counts of zero and above the maximum, and stale stored topics.
    task automatic test_topic_count_edges;
        cfg_write(REG_TOPIC, 0);
        send_token(make_token(ACT_INIT, 5, 3, 7, 16'hFFFF));
        send_token(make_token(ACT_RESAMPLE, 5, 3, 7, 16'h1234));
        drain();
        cfg_write(REG_TOPIC, 31);
        send_token(make_token(ACT_INIT, 5, 4, 7, 16'hFFFF));
        drain();
        // Slot 4 now holds topic 15; resampling with two topics removes it anyway.
        cfg_write(REG_TOPIC, 2);
        send_token(make_token(ACT_RESAMPLE, 5, 4, 7, 16'h9000));
        drain();
        cfg_write(REG_TOPIC, 1);
        send_token(make_token(ACT_RESAMPLE, 5, 16'hFFFF, 7, 16'hFFFF));
        drain();
        cfg_write(REG_TOPIC, 16);
    endtask

    // Zero denominators, zero grand total and saturated weights.
    task automatic test_weight_edges;
        cfg_write(REG_BETA, 0);
        cfg_write(REG_VOCAB, 1);
        send_token(make_token(ACT_RESAMPLE, 9, 3, 100, 16'h7000));
        drain();
        cfg_write(REG_ALPHA, 0);
        send_token(make_token(ACT_RESAMPLE, 900, 1, 200, 16'h0100));
        drain();
        cfg_write(REG_ALPHA, 32'hFFFF_FFFF);
        cfg_write(REG_BETA, 32'hFFFF_FFFF);
        cfg_write(REG_VOCAB, 4096);
        send_token(make_token(ACT_RESAMPLE, 0, 0, 0, 16'hC000));
        drain();
        cfg_write(REG_ALPHA, 6554);
        cfg_write(REG_BETA, 655);
    endtask

    // Validation mode leaves the word and total counts alone.
    task automatic test_validation_mode;
        cfg_write(REG_VALID, 1);
        send_token(make_token(ACT_INIT, 3, 10, 11, 16'h5555));
        send_token(make_token(ACT_RESAMPLE, 3, 10, 11, 16'hAAAA));
        send_token(make_token(ACT_RESAMPLE, 0, 0, 0, 16'h0001));
        drain();
        cfg_write(REG_VALID, 0);
    endtask

    // Random tokens, mostly resampling a small corpus so counts build up.
    task automatic test_random(input int count);
        int i;
        t_in_beat b;
        for (i = 0; i < count; i++) begin
            if (i % 60 == 0) begin
                drain();
                cfg_write(REG_TOPIC, (i % 180 == 0) ? 16 : $urandom_range(1, 8));
                cfg_write(REG_ALPHA, ($urandom_range(9) == 0) ? $urandom() :
                                     $urandom_range(1, 200000));
                cfg_write(REG_BETA, ($urandom_range(9) == 0) ? $urandom() :
                                    $urandom_range(1, 20000));
                cfg_write(REG_VOCAB, $urandom_range(1, 4096));
                cfg_write(REG_VALID, 32'($urandom_range(99) < 15));
                quiet = (i >= count / 2 && i < count / 2 + 60);
            end
            if (i == count / 3) drain();
            b.random_fraction = 16'($urandom());
            if ($urandom_range(99) < 80) begin
                b.doc_index = 10'($urandom_range(0, 7));
                b.word_id = 12'($urandom_range(0, 15));
            end else begin
                b.doc_index = 10'($urandom());
                b.word_id = 12'($urandom());
            end
            if (written_slots.size() != 0 && $urandom_range(99) < 65) begin
                b.action = ACT_RESAMPLE;
                b.token_slot =
                    16'(written_slots[$urandom_range(0, written_slots.size() - 1)]);
            end else begin
                b.action = ACT_INIT;
                b.token_slot = ($urandom_range(99) < 85) ? 16'($urandom_range(0, 127)) :
                                                           16'($urandom());
            end
            send_token(b);
        end
        quiet = 0;
        drain();
    endtask

    initial begin
        i_rst_n = 0;
        i_valid = 0;
        i_data = '0;
        i_stall = 0;
        i_cfg_valid = 0;
        i_cfg_index = REG_ALPHA;
        i_cfg_data = '0;
        sh_alpha = 6554;
        sh_beta = 655;
        sh_vocab = 4096;
        sh_topics = 16;
        sh_frozen = 0;
        foreach (doc_topic_cnt[j]) doc_topic_cnt[j] = '0;
        foreach (word_topic_cnt[j]) word_topic_cnt[j] = '0;
        foreach (topic_total[j]) topic_total[j] = '0;
        foreach (slot_topic[j]) slot_topic[j] = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;

        test_init_extremes();
        test_resample_basic();
        test_topic_count_edges();
        test_weight_edges();
        test_validation_mode();
        test_random(530);

        repeat (200) @(posedge i_clk);
        $display("Sent %0d tokens (%0d resamples), checked %0d draws over %0d slots.",
                 n_tokens, n_resamples, n_results, written_slots.size());
        $display("Covered topic-count, smoothing, vocabulary and validation-mode extremes.");
        if (n_errors == 0 && expected_draws.size() == 0) begin
            $display("** lda_gibbs_token_sampler: PASSED **");
        end else begin
            $display("%0d mismatches, %0d draws never arrived", n_errors, expected_draws.size());
            $display("** lda_gibbs_token_sampler: FAILED **");
        end
        $finish;
    end

endmodule
